// ===== hw/rtl/link_reconnect_backoff_fsm_unit_defines.svh =====
// Assertion macros used by the link reconnect controller checker.
// No dependencies; included by the checker file.
`ifndef LINK_RECONNECT_BACKOFF_FSM_UNIT_DEFINES_SVH
`define LINK_RECONNECT_BACKOFF_FSM_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define LRB_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define LRB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/lrb_pkg.sv =====
// Types, codes and constants of the link reconnect controller.
// No dependencies; used by the top level, lrb_step and the checker.
package lrb_pkg;

  typedef enum logic [1:0] {
    PH_IDLE         = 2'd0,
    PH_CONNECTING   = 2'd1,
    PH_CONNECTED    = 2'd2,
    PH_DISCONNECTED = 2'd3
  } phase_t;

  // Command codes of the input word.
  localparam logic [1:0] CMD_TICK       = 2'd0;
  localparam logic [1:0] CMD_CONNECT    = 2'd1;
  localparam logic [1:0] CMD_DISCONNECT = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MANAGER_ENABLED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LED_ENABLE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONNECT_TIMEOUT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_MIN     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_MAX     = 3'd4;

  localparam logic [15:0] CONNECT_TIMEOUT_RST = 16'd10000;
  localparam logic [15:0] BACKOFF_MIN_RST     = 16'd2000;
  localparam logic [15:0] BACKOFF_MAX_RST     = 16'd30000;

  // Blink half periods in milliseconds. The LED is on during the first half
  // of each full period, so a counter modulo the full period replaces a divide.
  localparam int FAST_BLINK_MS = 100;
  localparam int SLOW_BLINK_MS = 500;
  localparam int FAST_PERIOD   = 2 * FAST_BLINK_MS;
  localparam int SLOW_PERIOD   = 2 * SLOW_BLINK_MS;
  localparam int FAST_CW       = $clog2(FAST_PERIOD);
  localparam int SLOW_CW       = $clog2(SLOW_PERIOD);

  typedef struct packed {
    logic        manager_enabled;
    logic        led_enable;
    logic [15:0] connect_timeout_ms;
    logic [15:0] backoff_min_ms;
    logic [15:0] backoff_max_ms;
  } lrb_cfg_t;

  typedef struct packed {
    phase_t               phase;
    logic [31:0]          now_ms;
    logic [FAST_CW-1:0]   fast_pos;   // now_ms modulo FAST_PERIOD
    logic [SLOW_CW-1:0]   slow_pos;   // now_ms modulo SLOW_PERIOD
    logic [31:0]          attempt_start_ms;
    logic [31:0]          drop_time_ms;
    logic [15:0]          retry_delay_ms;
    logic [7:0]           fail_count;
    logic                 led_level;
  } lrb_state_t;

  typedef struct packed {
    logic [1:0] link_state;
    logic       status_led;
    logic       state_changed;
    logic       start_attempt;
    logic       drop_link;
    logic       accepted;
    logic [7:0] retry_count;
  } lrb_result_t;

endpackage

// ===== hw/rtl/lrb_if.sv =====
// Valid/ready channel interfaces for the command and result words.
// No dependencies beyond the language; used by the top level.
interface lrb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic       link_up;

  modport source (output valid, output cmd, output link_up, input ready);
  modport sink   (input valid, input cmd, input link_up, output ready);
endinterface

interface lrb_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] link_state;
  logic       status_led;
  logic       state_changed;
  logic       start_attempt;
  logic       drop_link;
  logic       accepted;
  logic [7:0] retry_count;

  modport source (output valid, output link_state, output status_led,
                  output state_changed, output start_attempt, output drop_link,
                  output accepted, output retry_count, input ready);
  modport sink   (input valid, input link_state, input status_led,
                  input state_changed, input start_attempt, input drop_link,
                  input accepted, input retry_count, output ready);
endinterface

// ===== hw/rtl/link_reconnect_backoff_fsm_unit.sv =====
// Top level of the link reconnect controller with exponential retry backoff.
// Depends on lrb_pkg, lrb_if (lrb_in_if, lrb_out_if) and lrb_step.
//
//   Channel   Direction  Handshake          Payload
//   in_if     sink       valid/ready        cmd[1:0], link_up
//   out_if    source     valid/ready        link_state, status_led, state_changed,
//                                           start_attempt, drop_link, accepted,
//                                           retry_count[7:0]
//   cfg_*     sink       cfg_we only        cfg_index[2:0], cfg_data[15:0]
//
// One word is accepted per clock cycle while the result is not stalled. The
// accepting edge loads the input register; the result register is written
// together with the state when the input register moves forward.
// The controller state is updated in the same cycle as the result register, so
// consecutive words see each other's effects with no bubbles.
// A stalled result holds the input register; words keep flowing as long as the
// result register is empty or being drained in the same cycle.
// Reset is synchronous and active low; no clearing pass is needed.
module link_reconnect_backoff_fsm_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lrb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrb_pkg::CFG_DATA_W-1:0] cfg_data,
  lrb_in_if.sink                         in_if,
  lrb_out_if.source                      out_if
);

  lrb_pkg::lrb_cfg_t    cfg_r;
  lrb_pkg::lrb_state_t  state_r;
  lrb_pkg::lrb_state_t  state_nxt;
  lrb_pkg::lrb_result_t step_res;
  lrb_pkg::lrb_result_t res_r;

  logic       s1_valid_r;
  logic [1:0] s1_cmd_r;
  logic       s1_link_r;
  logic       out_valid_r;
  logic       s1_go;
  logic       in_take;

  // The input register moves forward whenever the result register is empty
  // or its word is taken in this cycle.
  assign s1_go       = !out_valid_r || out_if.ready;
  assign in_if.ready = !s1_valid_r || s1_go;
  assign in_take     = in_if.valid && in_if.ready;

  // Configuration registers keep only their own width of the write data;
  // indexes beyond the register list fall into the default arm and are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.manager_enabled    <= 1'b0;
      cfg_r.led_enable         <= 1'b0;
      cfg_r.connect_timeout_ms <= lrb_pkg::CONNECT_TIMEOUT_RST;
      cfg_r.backoff_min_ms     <= lrb_pkg::BACKOFF_MIN_RST;
      cfg_r.backoff_max_ms     <= lrb_pkg::BACKOFF_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lrb_pkg::CFG_MANAGER_ENABLED: cfg_r.manager_enabled    <= cfg_data[0];
        lrb_pkg::CFG_LED_ENABLE:      cfg_r.led_enable         <= cfg_data[0];
        lrb_pkg::CFG_CONNECT_TIMEOUT: cfg_r.connect_timeout_ms <= cfg_data[15:0];
        lrb_pkg::CFG_BACKOFF_MIN:     cfg_r.backoff_min_ms     <= cfg_data[15:0];
        lrb_pkg::CFG_BACKOFF_MAX:     cfg_r.backoff_max_ms     <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // Input register stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_cmd_r  <= in_if.cmd;
      s1_link_r <= in_if.link_up;
    end
  end

  // All per-word work is one pass of combinational logic.
  lrb_step u_step (
    .cfg     (cfg_r),
    .st      (state_r),
    .cmd     (s1_cmd_r),
    .link_up (s1_link_r),
    .st_nxt  (state_nxt),
    .res     (step_res)
  );

  // Controller state: committed together with the result word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase            <= lrb_pkg::PH_IDLE;
      state_r.now_ms           <= '0;
      state_r.fast_pos         <= '0;
      state_r.slow_pos         <= '0;
      state_r.attempt_start_ms <= '0;
      state_r.drop_time_ms     <= '0;
      state_r.retry_delay_ms   <= lrb_pkg::BACKOFF_MIN_RST;
      state_r.fail_count       <= '0;
      state_r.led_level        <= 1'b0;
    end else if (s1_valid_r && s1_go) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_go) begin
      res_r <= step_res;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.link_state    = res_r.link_state;
  assign out_if.status_led    = res_r.status_led;
  assign out_if.state_changed = res_r.state_changed;
  assign out_if.start_attempt = res_r.start_attempt;
  assign out_if.drop_link     = res_r.drop_link;
  assign out_if.accepted      = res_r.accepted;
  assign out_if.retry_count   = res_r.retry_count;

endmodule

// ===== hw/rtl/lrb_step.sv =====
// Next-state and result logic of the link reconnect controller for one word.
// Depends on lrb_pkg.
module lrb_step (
  input  lrb_pkg::lrb_cfg_t    cfg,
  input  lrb_pkg::lrb_state_t  st,
  input  logic [1:0]           cmd,
  input  logic                 link_up,
  output lrb_pkg::lrb_state_t  st_nxt,
  output lrb_pkg::lrb_result_t res
);

  logic [31:0]                  now_inc;
  logic                         now_wrap;
  logic [lrb_pkg::FAST_CW-1:0]  fast_inc;
  logic [lrb_pkg::SLOW_CW-1:0]  slow_inc;
  logic [31:0]                  since_attempt;
  logic [31:0]                  since_drop;
  logic [16:0]                  delay_dbl;
  logic [15:0]                  delay_grown;
  logic                         led_blink;
  logic                         start;
  logic                         drop;
  logic                         acc;

  // Time base and the blink position counters that follow it. When the
  // 32-bit counter wraps to zero, the modulo counters restart with it.
  assign now_inc  = st.now_ms + 32'd1;
  assign now_wrap = &st.now_ms;
  assign fast_inc = (now_wrap ||
                     st.fast_pos == lrb_pkg::FAST_CW'(lrb_pkg::FAST_PERIOD - 1)) ?
                    '0 : st.fast_pos + lrb_pkg::FAST_CW'(1);
  assign slow_inc = (now_wrap ||
                     st.slow_pos == lrb_pkg::SLOW_CW'(lrb_pkg::SLOW_PERIOD - 1)) ?
                    '0 : st.slow_pos + lrb_pkg::SLOW_CW'(1);

  assign since_attempt = now_inc - st.attempt_start_ms;
  assign since_drop    = now_inc - st.drop_time_ms;

  // Doubled delay clamped to the ceiling; the clamp always fits 16 bits.
  assign delay_dbl   = {st.retry_delay_ms, 1'b0};
  assign delay_grown = (delay_dbl > {1'b0, cfg.backoff_max_ms}) ?
                       cfg.backoff_max_ms : delay_dbl[15:0];

  always_comb begin
    case (st.phase)
      lrb_pkg::PH_CONNECTING:
        led_blink = fast_inc < lrb_pkg::FAST_CW'(lrb_pkg::FAST_BLINK_MS);
      lrb_pkg::PH_CONNECTED:
        led_blink = 1'b1;
      lrb_pkg::PH_DISCONNECTED:
        led_blink = slow_inc < lrb_pkg::SLOW_CW'(lrb_pkg::SLOW_BLINK_MS);
      default:
        led_blink = 1'b0;
    endcase
  end

  always_comb begin
    st_nxt = st;
    start  = 1'b0;
    drop   = 1'b0;
    acc    = 1'b0;
    case (cmd)
      lrb_pkg::CMD_TICK: begin
        st_nxt.now_ms   = now_inc;
        st_nxt.fast_pos = fast_inc;
        st_nxt.slow_pos = slow_inc;
        if (cfg.manager_enabled) begin
          st_nxt.led_level = led_blink;
          case (st.phase)
            lrb_pkg::PH_CONNECTING: begin
              if (link_up) begin
                st_nxt.fail_count     = '0;
                st_nxt.retry_delay_ms = cfg.backoff_min_ms;
                st_nxt.phase          = lrb_pkg::PH_CONNECTED;
              end else if (since_attempt >= {16'd0, cfg.connect_timeout_ms}) begin
                drop = 1'b1;
                if (st.fail_count != 8'hFF) begin
                  st_nxt.fail_count = st.fail_count + 8'd1;
                end
                st_nxt.retry_delay_ms = delay_grown;
                st_nxt.drop_time_ms   = now_inc;
                st_nxt.phase          = lrb_pkg::PH_DISCONNECTED;
              end
            end
            lrb_pkg::PH_CONNECTED: begin
              if (!link_up) begin
                st_nxt.drop_time_ms = now_inc;
                st_nxt.phase        = lrb_pkg::PH_DISCONNECTED;
              end
            end
            lrb_pkg::PH_DISCONNECTED: begin
              if (since_drop >= {16'd0, st.retry_delay_ms}) begin
                start                   = 1'b1;
                st_nxt.attempt_start_ms = now_inc;
                st_nxt.phase            = lrb_pkg::PH_CONNECTING;
              end
            end
            default: begin
            end
          endcase
        end
      end
      lrb_pkg::CMD_CONNECT: begin
        if (cfg.manager_enabled) begin
          acc = 1'b1;
          if (st.phase != lrb_pkg::PH_CONNECTED) begin
            start                   = 1'b1;
            st_nxt.attempt_start_ms = st.now_ms;
            st_nxt.phase            = lrb_pkg::PH_CONNECTING;
          end
        end
      end
      lrb_pkg::CMD_DISCONNECT: begin
        drop                  = 1'b1;
        st_nxt.phase          = lrb_pkg::PH_IDLE;
        st_nxt.fail_count     = '0;
        st_nxt.retry_delay_ms = cfg.backoff_min_ms;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.link_state    = st_nxt.phase;
    res.status_led    = cfg.led_enable & st_nxt.led_level;
    res.state_changed = st_nxt.phase != st.phase;
    res.start_attempt = start;
    res.drop_link     = drop;
    res.accepted      = acc;
    res.retry_count   = st_nxt.fail_count;
  end

endmodule

// ===== hw/rtl/lrb_checker.sv =====
// Port-level checker for the link reconnect controller, bound to the top level.
// Depends on lrb_pkg and link_reconnect_backoff_fsm_unit_defines.svh.
`include "link_reconnect_backoff_fsm_unit_defines.svh"

module lrb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] link_state,
  input logic       state_changed,
  input logic       start_attempt,
  input logic       drop_link,
  input logic       accepted,
  input logic [7:0] retry_count
);

  // A result word that is not taken stays offered with the same contents.
  `LRB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable({link_state, state_changed, start_attempt, drop_link, accepted, retry_count}), "result word changed while stalled")

  // A started attempt always leaves the controller connecting.
  `LRB_ASSERT_IMPLY(a_start_connecting, clk, rst_n, out_valid && start_attempt, link_state == lrb_pkg::PH_CONNECTING && !drop_link, "attempt started outside the connecting state")

  // A teardown ends in idle (request) or disconnected (timeout).
  `LRB_ASSERT_IMPLY(a_drop_phase, clk, rst_n, out_valid && drop_link, link_state == lrb_pkg::PH_IDLE || link_state == lrb_pkg::PH_DISCONNECTED, "teardown left an active state")

  // An accepted connect request leaves the link connecting or connected.
  `LRB_ASSERT_IMPLY(a_accept_phase, clk, rst_n, out_valid && accepted, link_state == lrb_pkg::PH_CONNECTING || link_state == lrb_pkg::PH_CONNECTED, "accepted connect without an attempt or link")

endmodule

bind link_reconnect_backoff_fsm_unit lrb_checker u_lrb_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_if.valid),
  .out_ready     (out_if.ready),
  .link_state    (out_if.link_state),
  .state_changed (out_if.state_changed),
  .start_attempt (out_if.start_attempt),
  .drop_link     (out_if.drop_link),
  .accepted      (out_if.accepted),
  .retry_count   (out_if.retry_count)
);
